// ===== sv/slm_pkg.sv =====
// ----------------------------------------------------------------------------
// slm_pkg: shared types and constants of the stereo RMS level meter
// Field widths, fixed-point formats, shared-unit control and sample helpers.
// ----------------------------------------------------------------------------
package slm_pkg;

  localparam int SAMPLE_W = 16;               // Q1.15 sample
  localparam int LEVEL_W  = 15;               // level, units of 2^-15
  localparam int WEIGHT_W = 16;               // unsigned Q0.16 weight
  localparam int MAG_W    = 16;               // sample magnitude, up to 2^15
  localparam int PROD_W   = 2 * MAG_W;        // multiplier product
  localparam int MEAN_W   = 30;               // mean of squares, at most 2^28
  localparam int ROOT_W   = MEAN_W / 2;       // root digits, one per step
  localparam int SQREM_W  = ROOT_W + 3;       // square-root partial remainder

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd4588;  // about 0.07

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  // Control word for the shared add/subtract unit.
  typedef struct packed {
    alu_op_t op;
    logic    cin;   // carry in on add, borrow in on subtract
  } alu_ctrl_t;

  // Magnitude of a two's complement sample; the most negative code gives 2^15.
  function automatic logic [MAG_W-1:0] sample_mag(input logic [SAMPLE_W-1:0] s);
    logic [MAG_W-1:0] m;
    m = s[SAMPLE_W-1] ? MAG_W'(~s + 1'b1) : MAG_W'(s);
    return m;
  endfunction

endpackage

// ===== sv/slm_in_if.sv =====
// ----------------------------------------------------------------------------
// slm_in_if: stereo frame channel
// Valid/ready channel carrying one interleaved stereo frame per transaction.
// ----------------------------------------------------------------------------
interface slm_in_if import slm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;
  logic                       last_frame;

  modport source (output valid, left_sample, right_sample, last_frame, input ready);
  modport sink   (input valid, left_sample, right_sample, last_frame, output ready);
endinterface

// ===== sv/slm_out_if.sv =====
// ----------------------------------------------------------------------------
// slm_out_if: level result channel
// Valid/ready channel carrying the buffer RMS and smoothed level.
// ----------------------------------------------------------------------------
interface slm_out_if import slm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] rms_level;
  logic [LEVEL_W-1:0] smoothed_level;

  modport source (output valid, rms_level, smoothed_level, input ready);
  modport sink   (input valid, rms_level, smoothed_level, output ready);
endinterface

// ===== sv/slm_mul.sv =====
// ----------------------------------------------------------------------------
// slm_mul: shared unsigned multiplier
// 16x16 unsigned multiply with a registered product.
// ----------------------------------------------------------------------------
module slm_mul import slm_pkg::*; (
  input  logic              clk,
  input  logic [MAG_W-1:0]  a,
  input  logic [MAG_W-1:0]  b,
  output logic [PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ===== sv/slm_alu.sv =====
// ----------------------------------------------------------------------------
// slm_alu: shared add/subtract and compare unit
// Computes a + b + cin or a - b - cin; the carry out doubles as a >= b.
// ----------------------------------------------------------------------------
module slm_alu import slm_pkg::*; #(
  parameter int W = 18
) (
  input  alu_ctrl_t      ctrl,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic [W-1:0]   res,
  output logic           carry
);

  logic [W-1:0] b_eff;
  logic         c_eff;
  logic [W:0]   total;

  always_comb begin
    b_eff = (ctrl.op == ALU_SUB) ? ~b : b;
    c_eff = (ctrl.op == ALU_SUB) ? ~ctrl.cin : ctrl.cin;
    total = {1'b0, a} + {1'b0, b_eff} + (W+1)'(c_eff);
  end

  assign res   = total[W-1:0];
  assign carry = total[W];

endmodule

// ===== sv/stereo_rms_level_meter.sv =====
// ----------------------------------------------------------------------------
// stereo_rms_level_meter: stereo RMS level meter with exponential smoothing
// Accumulates halved squared samples per buffer, then emits floor(sqrt(mean))
// and an exponentially smoothed level on the frame marked last.
// ----------------------------------------------------------------------------
//
//  Channel   Kind          Width  Payload
//  -------   -----------   -----  ------------------------------------------
//  frame     sink v/r      33     left_sample, right_sample (s16), last_frame
//  level     source v/r    30     rms_level, smoothed_level (u15 each)
//  cfg       write strobe  16     cfg_we, cfg_wdata = smoothing_weight
//
//  A frame passes through accept, square left, square right and
//  accumulate, all through the one shared multiplier.
//  A last frame then adds one restoring-divide step per cycle for each of
//  the SUM_W sum bits (SUM_W = 39 at the default MAX_FRAMES) on the shared
//  subtract unit, 15 square-root steps on the same unit, then the smoothing
//  difference, scale and update. The meter waits in its final state while
//  the output register still holds an untaken result.
//  Reset is synchronous: it clears the sums, the smoothed level and the
//  output valid, and loads the default weight. No clearing pass is needed.
//
module stereo_rms_level_meter import slm_pkg::*; #(
  parameter int MAX_FRAMES = 512
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [WEIGHT_W-1:0] cfg_wdata,
  slm_in_if.sink              frame,
  slm_out_if.source           level
);

  // Sample count reaches at most 2*MAX_FRAMES; each halved square is at most
  // 2^28, so the sum needs 28 bits above the count width.
  localparam int CNT_LIMIT = 2 * MAX_FRAMES;
  localparam int CNT_W     = $clog2(CNT_LIMIT + 1);
  localparam int SUM_W     = 28 + CNT_W;
  localparam int REM_W     = CNT_W + 1;
  localparam int ALU_W     = (REM_W > SQREM_W) ? REM_W : SQREM_W;
  localparam int ITER_W    = $clog2(SUM_W);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_L,
    ST_SQ_R,
    ST_ACC_R,
    ST_DIV,
    ST_SQRT,
    ST_DIFF,
    ST_NEG,
    ST_SCALE,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  state_t              state;
  logic [WEIGHT_W-1:0] weight;
  logic [SUM_W-1:0]    sum;       // sum of squares, then quotient, then root feed
  logic [CNT_W-1:0]    count;
  logic [LEVEL_W-1:0]  smoothed;
  logic [MAG_W-1:0]    mag_l;
  logic [MAG_W-1:0]    mag_r;
  logic                last;
  logic                keep;      // frame fits in the buffer
  logic [REM_W-1:0]    rem;       // divide remainder
  logic [SQREM_W-1:0]  srem;      // square-root remainder
  logic [ROOT_W-1:0]   root;
  logic [ITER_W-1:0]   iter;
  logic [LEVEL_W-1:0]  diff;
  logic                up;        // new RMS at or above the smoothed level
  logic                out_valid;
  logic [LEVEL_W-1:0]  out_rms;
  logic [LEVEL_W-1:0]  out_smoothed;

  // Shared units
  logic [MAG_W-1:0]    mul_a;
  logic [MAG_W-1:0]    mul_b;
  logic [PROD_W-1:0]   prod;
  alu_ctrl_t           alu_ctrl;
  logic [ALU_W-1:0]    alu_a;
  logic [ALU_W-1:0]    alu_b;
  logic [ALU_W-1:0]    alu_res;
  logic                alu_ge;

  logic [REM_W-1:0]    div_shift;
  logic [SQREM_W-1:0]  sq_shift;
  logic [SUM_W-1:0]    sum_acc;
  logic                load_ok;

  slm_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  slm_alu #(.W(ALU_W)) u_alu (
    .ctrl  (alu_ctrl),
    .a     (alu_a),
    .b     (alu_b),
    .res   (alu_res),
    .carry (alu_ge)
  );

  // Bring the next dividend bit into the remainder; two bits for the root.
  assign div_shift = {rem[REM_W-2:0], sum[SUM_W-1]};
  assign sq_shift  = {srem[SQREM_W-3:0], sum[MEAN_W-1 -: 2]};
  assign sum_acc   = sum + SUM_W'(prod[PROD_W-1:2]);
  assign load_ok   = !out_valid || level.ready;

  // Multiplier operands: squares during accumulation, weight times
  // difference during smoothing.
  always_comb begin
    mul_a = mag_l;
    mul_b = mag_l;
    if (state == ST_SQ_R) begin
      mul_a = mag_r;
      mul_b = mag_r;
    end else if (state == ST_SCALE) begin
      mul_a = weight;
      mul_b = MAG_W'(diff);
    end
  end

  // Add/subtract-unit operands per sequencer step.
  always_comb begin
    alu_ctrl = '{op: ALU_SUB, cin: 1'b0};
    alu_a    = '0;
    alu_b    = '0;
    unique case (state)
      ST_DIV: begin
        alu_a = ALU_W'(div_shift);
        alu_b = ALU_W'(count);
      end
      ST_SQRT: begin
        alu_a = ALU_W'(sq_shift);
        alu_b = ALU_W'({root, 2'b01});
      end
      ST_DIFF: begin
        alu_a = ALU_W'(root);
        alu_b = ALU_W'(smoothed);
      end
      ST_NEG: begin
        alu_a = ALU_W'(smoothed);
        alu_b = ALU_W'(root);
      end
      ST_UPDATE: begin
        // Rising: add the truncated step. Falling: subtract the step
        // rounded up, which is the high half plus one if any low bit is set.
        alu_a = ALU_W'(smoothed);
        alu_b = ALU_W'(prod[PROD_W-1 -: WEIGHT_W]);
        if (up) begin
          alu_ctrl = '{op: ALU_ADD, cin: 1'b0};
        end else begin
          alu_ctrl = '{op: ALU_SUB, cin: |prod[PROD_W-WEIGHT_W-1:0]};
        end
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      weight    <= WEIGHT_RESET;
      sum       <= '0;
      count     <= '0;
      smoothed  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        weight <= cfg_wdata;
      end
      // Drop the held result once taken.
      if (level.ready && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (frame.valid) begin
            mag_l <= sample_mag(frame.left_sample);
            mag_r <= sample_mag(frame.right_sample);
            last  <= frame.last_frame;
            keep  <= (count < CNT_W'(CNT_LIMIT));
            state <= ST_SQ_L;
          end
        end
        ST_SQ_L: begin
          state <= ST_SQ_R;
        end
        ST_SQ_R: begin
          if (keep) begin
            sum <= sum_acc;
          end
          state <= ST_ACC_R;
        end
        ST_ACC_R: begin
          if (keep) begin
            sum   <= sum_acc;
            count <= count + CNT_W'(2);
          end
          rem  <= '0;
          iter <= ITER_W'(SUM_W - 1);
          state <= last ? ST_DIV : ST_IDLE;
        end
        ST_DIV: begin
          // Restoring divide: quotient bits shift into the sum register.
          rem <= alu_ge ? alu_res[REM_W-1:0] : div_shift;
          sum <= {sum[SUM_W-2:0], alu_ge};
          if (iter == '0) begin
            srem  <= '0;
            root  <= '0;
            iter  <= ITER_W'(ROOT_W - 1);
            state <= ST_SQRT;
          end else begin
            iter <= iter - 1'b1;
          end
        end
        ST_SQRT: begin
          srem <= alu_ge ? alu_res[SQREM_W-1:0] : sq_shift;
          root <= {root[ROOT_W-2:0], alu_ge};
          sum  <= {sum[SUM_W-3:0], 2'b00};
          if (iter == '0) begin
            state <= ST_DIFF;
          end else begin
            iter <= iter - 1'b1;
          end
        end
        ST_DIFF: begin
          up    <= alu_ge;
          diff  <= alu_res[LEVEL_W-1:0];
          state <= alu_ge ? ST_SCALE : ST_NEG;
        end
        ST_NEG: begin
          diff  <= alu_res[LEVEL_W-1:0];
          state <= ST_SCALE;
        end
        ST_SCALE: begin
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          smoothed <= alu_res[LEVEL_W-1:0];
          sum      <= '0;
          count    <= '0;
          state    <= ST_EMIT;
        end
        ST_EMIT: begin
          // Hold until the output register is free.
          if (load_ok) begin
            out_rms      <= root;
            out_smoothed <= smoothed;
            out_valid    <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign frame.ready          = (state == ST_IDLE);
  assign level.valid          = out_valid;
  assign level.rms_level      = out_rms;
  assign level.smoothed_level = out_smoothed;

  // Sample count never runs past the buffer size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CNT_LIMIT))
    else $error("sample count exceeds buffer limit");

  // An accepted frame always starts the square sequence.
  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    (frame.valid && frame.ready) |=> (state == ST_SQ_L))
    else $error("accepted frame did not start processing");

  // A new result appears only out of the final sequencer step.
  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_EMIT))
    else $error("result loaded outside the emit step");

  // The smoothed level stays within full scale.
  a_smoothed_range: assert property (@(posedge clk) disable iff (rst)
    smoothed <= LEVEL_W'(16384))
    else $error("smoothed level out of range");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stereo RMS level meter
// Drives stereo frames at random pace and checks every buffer level against
// a cycle-free model of the meter (sum of halved squares, floor mean, floor
// root, asymmetric rounding in the smoothing step), under several smoothing
// weights and across the buffer overrun limit.
// ----------------------------------------------------------------------------
module testbench;
  import slm_pkg::*;

  localparam int MAX_FRAMES    = 512;
  localparam int FRAME_TARGET  = 1450;  // total frames the run aims for
  localparam int STEADY_FRAMES = 60;    // frames sent with no idling at least
  localparam int QUIET_CYCLES  = 80;    // covers divide + root + smoothing
  localparam int STALL_LIMIT   = 2000;  // cycles with no transaction at all
  localparam int IDLE_PCT      = 31;    // idle share of cycles on each side
  localparam int PRINT_CAP     = 40;    // mismatch lines printed at most

  typedef struct packed {
    logic [LEVEL_W-1:0] rms;
    logic [LEVEL_W-1:0] smoothed;
  } level_pair_t;

  // Content styles for random buffers.
  typedef enum {TONE_FULL, TONE_EDGE, TONE_QUIET, TONE_LOUD} tone_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [WEIGHT_W-1:0] cfg_wdata;

  slm_in_if  frame_bus ();
  slm_out_if level_bus ();

  stereo_rms_level_meter #(.MAX_FRAMES(MAX_FRAMES)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .frame     (frame_bus),
    .level     (level_bus)
  );

  always #10 clk = ~clk;

  // Meter model state, kept in step with accepted frames.
  logic [38:0]         square_total = '0;
  logic [10:0]         samples_held = '0;
  logic [LEVEL_W-1:0]  smoothed_now = '0;
  logic [WEIGHT_W-1:0] weight_now   = WEIGHT_RESET;

  // Levels the meter still owes, oldest first.
  level_pair_t expected_levels[$];
  level_pair_t level_want;

  int errors          = 0;
  int frames_sent     = 0;
  int buffers_closed  = 0;
  int results_checked = 0;
  int weights_used    = 0;
  int stall_cycles    = 0;
  bit steady          = 1'b0;  // high: neither side idles

  // ---------------------------------------------------------------------------
  // Model
  // ---------------------------------------------------------------------------

  // floor((s/2)^2) in units of 2^-30; the most negative code has magnitude 2^15.
  function automatic logic [28:0] halved_square(input logic [SAMPLE_W-1:0] s);
    logic [16:0] mag;
    logic [33:0] sq;
    mag = s[SAMPLE_W-1] ? (17'h10000 - {1'b0, s}) : {1'b0, s};
    sq  = mag * mag;
    return sq[30:2];
  endfunction

  // Floor square root, one result bit per pass from the top.
  function automatic logic [15:0] root_floor(input logic [38:0] v);
    logic [15:0] r;
    logic [15:0] c;
    logic [63:0] sq;
    r = '0;
    for (int b = 15; b >= 0; b--) begin
      c  = r | (16'd1 << b);
      sq = 64'(c) * 64'(c);
      if (sq <= 64'(v)) r = c;
    end
    return r;
  endfunction

  // Advance the model by one accepted frame; queue a level on the last one.
  task automatic meter_frame(input logic [15:0] l, input logic [15:0] r, input logic last);
    logic [38:0] mean;
    logic [15:0] rms;
    logic [63:0] step;
    // Past the buffer limit, frames only count for their last flag.
    if (samples_held < 2 * MAX_FRAMES) begin
      square_total += halved_square(l) + halved_square(r);
      samples_held += 11'd2;
    end
    if (last) begin
      mean = (samples_held != 0) ? square_total / samples_held : '0;
      rms  = root_floor(mean);
      // Rising steps round down, falling steps round up: both toward -inf.
      if (rms >= smoothed_now) begin
        step = (64'(weight_now) * 64'(rms - smoothed_now)) >> 16;
        smoothed_now = smoothed_now + step[LEVEL_W-1:0];
      end else begin
        step = (64'(weight_now) * 64'(smoothed_now - rms) + 64'd65535) >> 16;
        smoothed_now = smoothed_now - step[LEVEL_W-1:0];
      end
      expected_levels.push_back('{rms: rms[LEVEL_W-1:0], smoothed: smoothed_now});
      square_total = '0;
      samples_held = '0;
      buffers_closed++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Level checking
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= PRINT_CAP)
      $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // Hold ready low at random, about IDLE_PCT percent of the time, except when steady.
  always @(posedge clk) begin
    level_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Compare each level transaction with the oldest pending expectation.
  always @(posedge clk) begin
    if (!rst && level_bus.valid && level_bus.ready) begin
      if (expected_levels.size() == 0) begin
        flag_mismatch("level with nothing pending, rms", level_bus.rms_level, -1);
      end else begin
        level_want = expected_levels.pop_front();
        results_checked++;
        if (level_bus.rms_level !== level_want.rms)
          flag_mismatch("rms_level", level_bus.rms_level, level_want.rms);
        if (level_bus.smoothed_level !== level_want.smoothed)
          flag_mismatch("smoothed_level", level_bus.smoothed_level, level_want.smoothed);
      end
    end
  end

  // Abort when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (frame_bus.valid && frame_bus.ready) || (level_bus.valid && level_bus.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Frame driving
  // ---------------------------------------------------------------------------

  // Present one frame, idling at random first, and hold it until taken.
  task automatic send_frame(input logic [15:0] l, input logic [15:0] r, input logic last);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      frame_bus.valid <= 1'b0;
      @(posedge clk);
    end
    frame_bus.valid        <= 1'b1;
    frame_bus.left_sample  <= l;
    frame_bus.right_sample <= r;
    frame_bus.last_frame   <= last;
    @(posedge clk);
    while (!frame_bus.ready) @(posedge clk);
    meter_frame(l, r, last);
    frames_sent++;
  endtask

  // Drop valid, wait for every owed level, then let the pipeline go quiet
  // so the next weight write lands on an idle meter.
  task automatic drain_levels();
    frame_bus.valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Write the smoothing weight; call only on an idle meter.
  task automatic set_weight(input logic [WEIGHT_W-1:0] w);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we     <= 1'b0;
    weight_now = w;
    weights_used++;
  endtask

  function automatic logic [15:0] pick_sample(input tone_t tone);
    logic [15:0] v;
    case (tone)
      TONE_EDGE: begin
        case ($urandom_range(5))
          0:       v = 16'h8000;
          1:       v = 16'h7FFF;
          2:       v = 16'h0000;
          3:       v = 16'hFFFF;
          4:       v = 16'h0001;
          default: v = 16'h8001;
        endcase
      end
      TONE_QUIET: v = 16'($urandom_range(511)) - 16'd256;
      TONE_LOUD: begin
        v = 16'($urandom_range(32767, 30000));
        if ($urandom_range(1) == 1) v = -v;
      end
      default: v = 16'($urandom());
    endcase
    return v;
  endfunction

  // Mostly short buffers, a quarter medium, a few long ones.
  function automatic int random_length();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return $urandom_range(8, 1);
    if (pick < 95) return $urandom_range(40, 9);
    return $urandom_range(120, 41);
  endfunction

  task automatic send_buffer(input int frames, input tone_t tone);
    for (int i = 0; i < frames; i++)
      send_frame(pick_sample(tone), pick_sample(tone), i == frames - 1);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Single-frame buffers at the sample extremes under the reset weight,
  // then one mixed buffer and a silent one to force a falling step.
  task automatic test_directed();
    send_frame(16'h0000, 16'h0000, 1'b1);
    send_frame(16'h8000, 16'h8000, 1'b1);  // full scale: rms 16384
    send_frame(16'h7FFF, 16'h7FFF, 1'b1);
    send_frame(16'h8000, 16'h7FFF, 1'b1);
    send_frame(16'h0001, 16'hFFFF, 1'b1);  // smallest nonzero: square floors to 0
    send_frame(16'hFFFF, 16'h0000, 1'b1);
    send_frame(16'h5555, 16'hAAAA, 1'b1);
    send_frame(16'hAAAA, 16'h5555, 1'b1);
    send_frame(16'h7FFF, 16'h8000, 1'b0);
    send_frame(16'h0000, 16'h0000, 1'b0);
    send_frame(16'h3039, 16'hCFC7, 1'b0);
    send_frame(16'hFFFF, 16'h0001, 1'b1);
    send_frame(16'h0000, 16'h0000, 1'b1);  // silence after loud: falling step
    drain_levels();
  endtask

  // Zero weight freezes the smoothed level, full weight nearly tracks the
  // RMS; alternate loud and quiet buffers so both step directions round.
  task automatic test_weight_extremes();
    logic [WEIGHT_W-1:0] weights [5];
    weights = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'hFFFE};
    foreach (weights[k]) begin
      set_weight(weights[k]);
      send_buffer(random_length(), TONE_LOUD);
      send_buffer(random_length(), TONE_QUIET);
      send_buffer(random_length(), TONE_EDGE);
      send_buffer(random_length(), TONE_FULL);
      drain_levels();
    end
  endtask

  // Overrun: frames past the limit must not enter the sum. The first buffer
  // fills the limit at full scale and pads with silence, so any padding that
  // leaks in pulls the level down; it also reaches the largest possible sum.
  task automatic test_buffer_overrun();
    set_weight(16'($urandom()));
    for (int i = 0; i < MAX_FRAMES + 8; i++)
      send_frame(i < MAX_FRAMES ? 16'h8000 : 16'h0000,
                 i < MAX_FRAMES ? 16'h8000 : 16'h0000,
                 i == MAX_FRAMES + 7);
    // Last frame lands exactly one past the limit.
    send_buffer(MAX_FRAMES + 1, TONE_FULL);
    // Short buffer right after: the sum and count must start from zero.
    send_buffer(3, TONE_LOUD);
    drain_levels();
  endtask

  // Random weights, mixed content, mixed buffer lengths.
  task automatic test_random_buffers();
    for (int p = 0; p < 1 || frames_sent < FRAME_TARGET - 150; p++) begin
      case ($urandom_range(9))
        0:       set_weight(16'h0000);
        1:       set_weight(16'hFFFF);
        2:       set_weight(WEIGHT_RESET);
        default: set_weight(16'($urandom()));
      endcase
      repeat (6) send_buffer(random_length(), tone_t'($urandom_range(3)));
      drain_levels();
    end
  endtask

  // Back-to-back traffic: no idling on either side.
  task automatic test_back_to_back();
    int start_count;
    start_count = frames_sent;
    steady = 1'b1;
    set_weight(16'($urandom()));
    while (frames_sent - start_count < STEADY_FRAMES || frames_sent < FRAME_TARGET)
      send_buffer(random_length(), tone_t'($urandom_range(3)));
    drain_levels();
    steady = 1'b0;
  endtask

  initial begin
    rst                    <= 1'b1;
    cfg_we                 <= 1'b0;
    cfg_wdata              <= '0;
    frame_bus.valid        <= 1'b0;
    frame_bus.left_sample  <= '0;
    frame_bus.right_sample <= '0;
    frame_bus.last_frame   <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_weight_extremes();
    test_buffer_overrun();
    test_random_buffers();
    test_back_to_back();

    $display("run: %0d frames in %0d buffers, %0d levels compared, %0d mismatches",
             frames_sent, buffers_closed, results_checked, errors);
    $display("run: %0d weight writes incl. zero and full scale, overrun past %0d frames",
             weights_used, MAX_FRAMES);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/slm_pkg.sv
sv/slm_in_if.sv
sv/slm_out_if.sv
sv/slm_mul.sv
sv/slm_alu.sv
sv/stereo_rms_level_meter.sv
tb/testbench.sv
